// File: rtl/bvd_pkg.sv
// bvd_pkg: shared types, constants and helpers for the button vote debouncer
// no dependencies; imported by every rtl file of the block

package bvd_pkg;

   localparam int BUTTONS          = 3;
   localparam int HISTORY_BITS     = 8;
   localparam int ONES_W           = $clog2(HISTORY_BITS + 1);
   localparam int TIME_W           = 32;
   localparam int TIMEOUT_W        = 8;
   localparam int SLEEP_UNIT_S     = 5;
   localparam int MS_PER_S         = 1000;
   localparam int SLEEP_UNIT_MS    = SLEEP_UNIT_S * MS_PER_S;
   localparam int WINDOW_W         = TIMEOUT_W + $clog2(SLEEP_UNIT_MS + 1);
   localparam int CSR_INDEX_W      = 1;
   localparam int CSR_DATA_W       = 8;

   localparam logic [ONES_W-1:0]       PRESS_MIN_ONES   = ONES_W'(4);
   localparam logic [ONES_W-1:0]       RELEASE_MAX_ONES = ONES_W'(4);
   localparam logic [HISTORY_BITS-1:0] WAKE_HISTORY     = HISTORY_BITS'(4);

   // command codes carried in the word
   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_WAKE   = 1'b1;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_HANDLER_ENABLE = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_SLEEP_TIMEOUT  = CSR_INDEX_W'(1);

   typedef struct packed {
      logic               cmd;
      logic [BUTTONS-1:0] raw_levels;
      logic [BUTTONS-1:0] handler_accepts;
      logic [TIME_W-1:0]  now_ms;
   } req_type;

   typedef struct packed {
      logic [BUTTONS-1:0] held;
      logic [BUTTONS-1:0] handler_calls;
      logic [BUTTONS-1:0] press_events;
      logic               active;
   } rsp_type;

   typedef struct packed {
      logic [BUTTONS-1:0]  handler_enable;
      logic [WINDOW_W-1:0] window_ms;
      logic                always_active;
   } cfg_type;

   typedef struct packed {
      logic held;
      logic handler_call;
      logic press_evt;
      logic recent;
   } btn_status_type;

   function automatic logic [ONES_W-1:0] ones_in(input logic [HISTORY_BITS-1:0] v);
      logic [ONES_W-1:0] n;
      n = '0;
      for (int i = 0; i < HISTORY_BITS; i++) begin
         n = n + ONES_W'(v[i]);
      end
      return n;
   endfunction

endpackage

// File: rtl/button_vote_debouncer_core.sv
// button_vote_debouncer_core: an accepted req word goes into the input register,
// then into the result register, which drives rsp valid; a full result register
// that is not read holds the word back. One word per cycle while rsp_ready stays
// high, with a single pass through the button lanes between the two registers.
// reset (synchronous, active high) clears histories, flags, press times and both
// valid flags; an empty pipe accepts a word once reset is released. depends on bvd_pkg, bvd_csr, bvd_button

module button_vote_debouncer_core
   import bvd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_data,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type        cfg;
   btn_status_type status [BUTTONS];

   logic    in_valid_ff, in_valid_in;
   req_type in_word_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_word_ff, out_word_in;
   logic    advance;
   logic    req_take;
   logic    any_recent;

   bvd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // the buffered word moves to the result register when that one is empty or its word is being taken
   assign advance   = in_valid_ff & (~out_valid_ff | rsp_ready);
   assign req_ready = ~in_valid_ff | advance;
   assign req_take  = req_valid & req_ready;

   for (genvar b = 0; b < BUTTONS; b++) begin : g_btn
      bvd_button u_btn (
         .clock          (clock),
         .reset          (reset),
         .advance        (advance),
         .cmd            (in_word_ff.cmd),
         .raw_level      (in_word_ff.raw_levels[b]),
         .handler_accept (in_word_ff.handler_accepts[b]),
         .handler_enable (cfg.handler_enable[b]),
         .now_ms         (in_word_ff.now_ms),
         .window_ms      (cfg.window_ms),
         .status         (status[b])
      );
   end

   always_comb begin
      any_recent = 1'b0;
      for (int b = 0; b < BUTTONS; b++) begin
         out_word_in.held[b]          = status[b].held;
         out_word_in.handler_calls[b] = status[b].handler_call;
         out_word_in.press_events[b]  = status[b].press_evt;
         any_recent                   = any_recent | status[b].recent;
      end
      out_word_in.active = cfg.always_active | any_recent;
   end

   assign in_valid_in  = req_take | (in_valid_ff & ~advance);
   assign out_valid_in = advance | (out_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_word_ff <= req_data;
      end
      if (advance) begin
         out_word_ff <= out_word_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_word_ff;

endmodule

// File: rtl/bvd_csr.sv
// bvd_csr: configuration registers, with the sleep window precomputed in ms
// depends on bvd_pkg

module bvd_csr
   import bvd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output cfg_type                cfg
);

   logic [BUTTONS-1:0]  handler_enable_ff, handler_enable_in;
   logic [WINDOW_W-1:0] window_ff, window_in;
   logic                always_active_ff, always_active_in;
   logic [TIMEOUT_W-1:0] timeout_wr;

   assign timeout_wr = csr_wdata[TIMEOUT_W-1:0];

   always_comb begin
      handler_enable_in = handler_enable_ff;
      window_in         = window_ff;
      always_active_in  = always_active_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_HANDLER_ENABLE: begin
               handler_enable_in = csr_wdata[BUTTONS-1:0];
            end
            CSR_SLEEP_TIMEOUT: begin
               window_in        = WINDOW_W'(timeout_wr) * WINDOW_W'(SLEEP_UNIT_MS);
               always_active_in = (timeout_wr == '0);
            end
            default: begin
               handler_enable_in = handler_enable_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         handler_enable_ff <= '0;
         window_ff         <= '0;
         always_active_ff  <= 1'b1;
      end else begin
         handler_enable_ff <= handler_enable_in;
         window_ff         <= window_in;
         always_active_ff  <= always_active_in;
      end
   end

   assign cfg.handler_enable = handler_enable_ff;
   assign cfg.window_ms      = window_ff;
   assign cfg.always_active  = always_active_ff;

endmodule

// File: rtl/bvd_button.sv
// bvd_button: one button lane: sample history, press flags, press time
// depends on bvd_pkg

module bvd_button
   import bvd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                cmd,
   input  logic                raw_level,
   input  logic                handler_accept,
   input  logic                handler_enable,
   input  logic [TIME_W-1:0]   now_ms,
   input  logic [WINDOW_W-1:0] window_ms,
   output btn_status_type      status
);

   logic [HISTORY_BITS-1:0] history_ff, history_in;
   logic                    captured_ff, captured_in;
   logic                    done_ff, done_in;
   logic [TIME_W-1:0]       last_ff, last_in;

   logic                    pressed;
   logic [HISTORY_BITS-1:0] shifted;
   logic [ONES_W-1:0]       ones;
   logic [TIME_W-1:0]       elapsed;

   assign pressed = ~raw_level;
   assign shifted = {history_ff[HISTORY_BITS-2:0], pressed};
   assign ones    = ones_in(shifted);

   always_comb begin
      history_in          = history_ff;
      captured_in         = captured_ff;
      done_in             = done_ff;
      last_in             = last_ff;
      status.held         = 1'b0;
      status.handler_call = 1'b0;
      status.press_evt    = 1'b0;
      if (cmd == CMD_WAKE) begin
         history_in  = WAKE_HISTORY;
         captured_in = 1'b1;
         done_in     = 1'b1;
         last_in     = now_ms;
      end else begin
         history_in = shifted;
         if (pressed) begin
            if (ones >= PRESS_MIN_ONES) begin
               status.held = 1'b1;
               if (!captured_ff) begin
                  last_in     = now_ms;
                  captured_in = 1'b1;
               end
               status.handler_call = ~done_ff & handler_enable;
               status.press_evt    = ~done_ff & handler_enable & handler_accept;
               done_in             = done_ff | status.press_evt;
            end
         end else if (ones <= RELEASE_MAX_ONES) begin
            captured_in = 1'b0;
            done_in     = 1'b0;
         end
      end
      // activity looks at the press time after this word's update
      elapsed       = now_ms - last_in;
      status.recent = (elapsed < TIME_W'(window_ms));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         history_ff  <= '0;
         captured_ff <= 1'b0;
         done_ff     <= 1'b0;
         last_ff     <= '0;
      end else if (advance) begin
         history_ff  <= history_in;
         captured_ff <= captured_in;
         done_ff     <= done_in;
         last_ff     <= last_in;
      end
   end

endmodule

// File: verif/tb_button_vote_debouncer_core.sv
// tb_button_vote_debouncer_core: self-checking bench for the button vote debouncer,
// with a tracking scoreboard, directed press/release/wake words and random traffic
// depends on bvd_pkg and button_vote_debouncer_core

module tb_button_vote_debouncer_core;
   import bvd_pkg::*;

   localparam int STALL_LIMIT = 2000;

   // debounce tracker: mirrors histories, flags and press times, queues the
   // expected result of every accepted word
   class debounce_scoreboard;
      logic [HISTORY_BITS-1:0] history [BUTTONS];
      bit                      captured [BUTTONS];
      bit                      done [BUTTONS];
      logic [TIME_W-1:0]       press_ms [BUTTONS];
      logic [BUTTONS-1:0]      enable_mask;
      logic [TIMEOUT_W-1:0]    timeout_units;
      rsp_type                 expected_q [$];
      int                      errors;

      function void clear();
         for (int i = 0; i < BUTTONS; i++) begin
            history[i]  = '0;
            captured[i] = 0;
            done[i]     = 0;
            press_ms[i] = '0;
         end
         enable_mask   = '0;
         timeout_units = '0;
         errors        = 0;
      endfunction

      function void set_register(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         if (idx == CSR_HANDLER_ENABLE) begin
            enable_mask = val[BUTTONS-1:0];
         end else if (idx == CSR_SLEEP_TIMEOUT) begin
            timeout_units = val[TIMEOUT_W-1:0];
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function logic recently_pressed(logic [TIME_W-1:0] now);
         longint unsigned  window;
         logic [TIME_W-1:0] since;
         if (timeout_units == 0) return 1'b1;
         window = longint'(timeout_units) * SLEEP_UNIT_MS;
         for (int i = 0; i < BUTTONS; i++) begin
            since = now - press_ms[i];   // wraps at 32 bits
            if (longint'(since) < window) return 1'b1;
         end
         return 1'b0;
      endfunction

      function void note_word(req_type w);
         rsp_type                 r;
         logic [HISTORY_BITS-1:0] h;
         bit                      pressed;
         r = '0;
         if (w.cmd == CMD_WAKE) begin
            for (int i = 0; i < BUTTONS; i++) begin
               history[i]  = WAKE_HISTORY;
               captured[i] = 1;
               done[i]     = 1;
               press_ms[i] = w.now_ms;
            end
         end else begin
            for (int i = 0; i < BUTTONS; i++) begin
               pressed = !w.raw_levels[i];
               h = {history[i][HISTORY_BITS-2:0], pressed};
               if (pressed) begin
                  if ($countones(h) >= PRESS_MIN_ONES) begin
                     r.held[i] = 1'b1;
                     if (!captured[i]) begin
                        press_ms[i] = w.now_ms;
                        captured[i] = 1;
                     end
                     if (!done[i] && enable_mask[i]) begin
                        r.handler_calls[i] = 1'b1;
                        if (w.handler_accepts[i]) begin
                           done[i] = 1;
                           r.press_events[i] = 1'b1;
                        end
                     end
                  end
               end else if ($countones(h) <= RELEASE_MAX_ONES) begin
                  captured[i] = 0;
                  done[i]     = 0;
               end
               history[i] = h;
            end
         end
         r.active = recently_pressed(w.now_ms);
         expected_q.push_back(r);
      endfunction

      function void compare_field(string label, logic [BUTTONS-1:0] want,
                                  logic [BUTTONS-1:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %b actual %b", $time, label, want, got);
            errors++;
         end
      endfunction

      function void check_word(rsp_type got);
         rsp_type want;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result word, expected none actual %h", $time, got);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         compare_field("held", want.held, got.held);
         compare_field("handler_calls", want.handler_calls, got.handler_calls);
         compare_field("press_events", want.press_events, got.press_events);
         compare_field("active", BUTTONS'(want.active), BUTTONS'(got.active));
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   req_type                req_data;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   logic                   quiet;   // no idling on either side while set
   int                     stall_cycles = 0;
   debounce_scoreboard     tracker = new;

   button_vote_debouncer_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_ready <= (quiet === 1'b1) ? 1'b1 : ($urandom_range(99) >= 8);
   end

   // word monitor and watchdog
   always @(posedge clock) begin
      if (reset === 1'b0) begin
         if (req_valid && req_ready) tracker.note_word(req_data);
         if (rsp_valid && rsp_ready) tracker.check_word(rsp_data);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            stall_cycles <= 0;
         end else if (stall_cycles + 1 >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
      end
   end

   function automatic req_type make_word(logic c, logic [BUTTONS-1:0] raw,
                                         logic [BUTTONS-1:0] acc, logic [TIME_W-1:0] at_ms);
      req_type w;
      w.cmd             = c;
      w.raw_levels      = raw;
      w.handler_accepts = acc;
      w.now_ms          = at_ms;
      return w;
   endfunction

   // returns at the edge where the word is taken; valid stays high for a follow-on word
   task automatic send_word(input req_type w);
      if (!quiet && $urandom_range(99) < 8) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic drain_words();
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
   endtask

   task automatic configure(input logic [BUTTONS-1:0] enable,
                            input logic [TIMEOUT_W-1:0] timeout);
      csr_we    <= 1'b1;
      csr_index <= CSR_HANDLER_ENABLE;
      csr_wdata <= CSR_DATA_W'(enable);
      @(posedge clock);
      tracker.set_register(CSR_HANDLER_ENABLE, CSR_DATA_W'(enable));
      csr_index <= CSR_SLEEP_TIMEOUT;
      csr_wdata <= CSR_DATA_W'(timeout);
      @(posedge clock);
      tracker.set_register(CSR_SLEEP_TIMEOUT, CSR_DATA_W'(timeout));
      csr_we <= 1'b0;
   endtask

   // buttons mostly hold a level for a dozen ticks with some bounce; a share of
   // words is pure noise, a few are wake commands, time mostly steps by ~10 ms
   task automatic run_random(input int count, input logic [TIME_W-1:0] start_ms);
      logic [TIME_W-1:0]  t;
      logic [BUTTONS-1:0] level, raw, acc;
      logic               c;
      int                 roll, step_roll;
      t = start_ms;
      level = '1;
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(99);
         for (int b = 0; b < BUTTONS; b++) begin
            if ($urandom_range(11) == 0) level[b] = ~level[b];
            raw[b] = ($urandom_range(99) < 12) ? ~level[b] : level[b];
         end
         if (roll < 12) raw = BUTTONS'($urandom);
         acc = ($urandom_range(99) < 60) ? '1 : BUTTONS'($urandom);
         c = (roll >= 96) ? CMD_WAKE : CMD_SAMPLE;
         step_roll = $urandom_range(99);
         if (step_roll < 3) t = $urandom;
         else if (step_roll < 8) t = t + $urandom_range(1_400_000);
         else t = t + $urandom_range(5, 15);
         send_word(make_word(c, raw, acc, t));
      end
   endtask

   initial begin
      logic [BUTTONS-1:0]   phase_enable [6];
      logic [TIMEOUT_W-1:0] phase_timeout [6];
      logic [TIME_W-1:0]    t;

      phase_enable  = '{3'b000, 3'b111, 3'b101, 3'b010, 3'b111, 3'b011};
      phase_timeout = '{8'd0, 8'd255, 8'd1, 8'd3, 8'd2, 8'd40};
      phase_enable[5]  = BUTTONS'($urandom);
      phase_timeout[5] = TIMEOUT_W'($urandom_range(1, 255));

      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_we    <= 1'b0;
      csr_index <= CSR_HANDLER_ENABLE;
      csr_wdata <= '0;
      quiet     <= 1'b0;
      tracker.clear();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      configure(3'b111, 8'd1);

      // full press: held from the fourth sample, calls refused, then accepted per button
      t = 32'd10;
      for (int k = 0; k < 5; k++) begin
         send_word(make_word(CMD_SAMPLE, 3'b000, 3'b000, t));
         t = t + 10;
      end
      send_word(make_word(CMD_SAMPLE, 3'b000, 3'b101, t));
      t = t + 10;
      send_word(make_word(CMD_SAMPLE, 3'b000, 3'b111, t));
      t = t + 10;
      send_word(make_word(CMD_SAMPLE, 3'b000, 3'b111, t));
      t = t + 10;
      for (int k = 0; k < 6; k++) begin
         send_word(make_word(CMD_SAMPLE, 3'b111, 3'b111, t));
         t = t + 10;
      end
      // wake just below the 32-bit wrap, then window edges across the wrap
      send_word(make_word(CMD_WAKE, 3'b010, 3'b111, 32'hFFFF_FFF0));
      send_word(make_word(CMD_SAMPLE, 3'b101, 3'b111, 32'h0000_0005));
      send_word(make_word(CMD_SAMPLE, 3'b111, 3'b000, 32'hFFFF_FFF0 + 32'd4999));
      send_word(make_word(CMD_SAMPLE, 3'b111, 3'b000, 32'hFFFF_FFF0 + 32'd5000));
      send_word(make_word(CMD_SAMPLE, 3'b011, 3'b100, 32'hFFFF_FFFF));
      send_word(make_word(CMD_SAMPLE, 3'b000, 3'b010, 32'h0000_0000));
      drain_words();

      for (int p = 0; p < 6; p++) begin
         configure(phase_enable[p], phase_timeout[p]);
         quiet <= (p == 2);
         run_random(225, (p == 1) ? 32'hFFFF_F000 : $urandom);
         drain_words();
      end

      repeat (4) @(posedge clock);
      tracker.errors = tracker.errors + tracker.pending();
      if (tracker.errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
